// ----- rtl/core/cst_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and defaults of the client session table.
package cst_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [1:0] CMD_BCAST      = 2'd0;
  localparam logic [1:0] CMD_ADDR_QUERY = 2'd1;
  localparam logic [1:0] CMD_OTHER      = 2'd2;
  localparam logic [1:0] CMD_TICK       = 2'd3;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_CREATED = 3'd1;
  localparam logic [2:0] ST_REUSED  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_TICK    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_IP_LIMIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HARD_TIMEOUT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_OVERRIDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE_EN   = 3'd4;

  localparam logic [4:0]  IP_LIMIT_RST      = 5'd4;
  localparam logic [15:0] SOFT_TIMEOUT_RST  = 16'd5;
  localparam logic [31:0] HARD_TIMEOUT_RST  = 32'd3600;
  localparam logic [15:0] PORT_OVERRIDE_RST = 16'd8055;
  localparam logic        OVERRIDE_EN_RST   = 1'b1;

  localparam logic [4:0] COUNT_SAT = 5'd31;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] src_ip;
    logic [15:0] src_port;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [15:0] forward_mask;
    logic        reply_valid;
    logic [31:0] reply_ip;
    logic [4:0]  online_count;
    logic [4:0]  idle_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] last_seen;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctl_cmd_t;

endpackage

// ----- rtl/core/cst_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module cst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/cst_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the client session table: accept, table scan, drain and finish.
module cst_ctrl #(
  parameter int unsigned TABLE_ENTRIES = cst_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output cst_pkg::ctl_cmd_t   cmd,
  output logic [IDX_W-1:0]    rd_addr
);
  import cst_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             drain_r, drain_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    drain_nxt = drain_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
          drain_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      drain_r <= drain_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.load   = start && (state_r == S_IDLE);
  assign cmd.scan   = (state_r == S_SCAN);
  assign cmd.finish = (state_r == S_FINISH);
  assign rd_addr    = idx_r;

endmodule

// ----- rtl/core/cst_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the client session table: registers, entry store, scan pipeline and result.
module cst_datapath #(
  parameter int unsigned TABLE_ENTRIES = cst_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cst_pkg::ctl_cmd_t                  cmd,
  input  logic [IDX_W-1:0]                   rd_addr,
  input  cst_pkg::in_item_t                  in_data,
  input  logic                               cfg_wr,
  input  logic [cst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cst_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               out_valid,
  output cst_pkg::out_item_t                 out_data
);
  import cst_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W : 5;

  // Configuration registers.
  logic [4:0]  ip_limit_r;
  logic [15:0] soft_timeout_r;
  logic [31:0] hard_timeout_r;
  logic [15:0] port_override_r;
  logic        override_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_limit_r      <= IP_LIMIT_RST;
      soft_timeout_r  <= SOFT_TIMEOUT_RST;
      hard_timeout_r  <= HARD_TIMEOUT_RST;
      port_override_r <= PORT_OVERRIDE_RST;
      override_en_r   <= OVERRIDE_EN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_IP_LIMIT:      ip_limit_r      <= cfg_data[4:0];
        REG_SOFT_TIMEOUT:  soft_timeout_r  <= cfg_data[15:0];
        REG_HARD_TIMEOUT:  hard_timeout_r  <= cfg_data[31:0];
        REG_PORT_OVERRIDE: port_override_r <= cfg_data[15:0];
        REG_OVERRIDE_EN:   override_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Item under work and the seconds counter.
  logic [1:0]  cmd_r;
  logic [31:0] ip_r;
  logic [15:0] port_r;
  logic [31:0] sec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r <= '0;
    end else if (cmd.load && (in_data.cmd == CMD_TICK)) begin
      sec_r <= sec_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_data.cmd;
      ip_r   <= in_data.src_ip;
      port_r <= override_en_r ? port_override_r : in_data.src_port;
    end
  end

  // Entry store: fields in RAM, valid bits in flops.
  logic [TABLE_ENTRIES-1:0] valid_r;
  entry_t                   rd_entry;
  entry_t                   wr_entry;
  logic                     ram_we;
  logic [IDX_W-1:0]         sel_idx;

  cst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sel_idx),
    .wdata (wr_entry),
    .re    (cmd.scan),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  // Stage one: RAM output compared and aged.
  logic             s1_v_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s2_v_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic             s2_ip_eq_r;
  logic             s2_port_eq_r;
  logic [31:0]      s2_age_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.scan;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r     <= rd_addr;
    s2_idx_r     <= s1_idx_r;
    s2_ip_eq_r   <= (rd_entry.ip == ip_r);
    s2_port_eq_r <= (rd_entry.port == port_r);
    s2_age_r     <= sec_r - rd_entry.last_seen;
  end

  // Stage two: accumulate hit, free slot, reuse candidate and tick counts.
  logic             is_tick;
  logic             ent_valid;
  logic             same_ip;
  logic             take_best;
  logic [IDX_W-1:0] best_idx_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic [4:0]       limit_eff;
  logic             reach;

  logic             hit_found_r, free_found_r, reuse_found_r, have_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r, reuse_idx_r, best_idx_r;
  logic [31:0]      best_age_r;
  logic [CNT_W-1:0] cnt_r;
  logic [4:0]       online_r, idle_r;

  assign is_tick      = (cmd_r == CMD_TICK);
  assign ent_valid    = valid_r[s2_idx_r];
  assign same_ip      = s2_v_r && !is_tick && ent_valid && s2_ip_eq_r;
  assign take_best    = !have_r || (s2_age_r > best_age_r);
  assign best_idx_nxt = take_best ? s2_idx_r : best_idx_r;
  assign cnt_nxt      = cnt_r + 1'b1;
  assign limit_eff    = (ip_limit_r == 5'd0) ? 5'd1 : ip_limit_r;
  assign reach        = (CMP_W'(cnt_nxt) >= CMP_W'(limit_eff));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r   <= 1'b0;
      free_found_r  <= 1'b0;
      reuse_found_r <= 1'b0;
      have_r        <= 1'b0;
      cnt_r         <= '0;
      online_r      <= '0;
      idle_r        <= '0;
    end else if (cmd.load) begin
      hit_found_r   <= 1'b0;
      free_found_r  <= 1'b0;
      reuse_found_r <= 1'b0;
      have_r        <= 1'b0;
      cnt_r         <= '0;
      online_r      <= '0;
      idle_r        <= '0;
    end else if (s2_v_r) begin
      if (is_tick) begin
        if (ent_valid && (s2_age_r <= hard_timeout_r)) begin
          if (s2_age_r > 32'(soft_timeout_r)) begin
            if (idle_r != COUNT_SAT) begin
              idle_r <= idle_r + 5'd1;
            end
          end else if (online_r != COUNT_SAT) begin
            online_r <= online_r + 5'd1;
          end
        end
      end else begin
        if (ent_valid && s2_ip_eq_r && s2_port_eq_r && !hit_found_r) begin
          hit_found_r <= 1'b1;
        end
        if (!ent_valid && !free_found_r) begin
          free_found_r <= 1'b1;
        end
        if (same_ip && !reuse_found_r) begin
          have_r <= 1'b1;
          cnt_r  <= cnt_nxt;
          if (reach) begin
            reuse_found_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && !is_tick) begin
      if (ent_valid && s2_ip_eq_r && s2_port_eq_r && !hit_found_r) begin
        hit_idx_r <= s2_idx_r;
      end
      if (!ent_valid && !free_found_r) begin
        free_idx_r <= s2_idx_r;
      end
      if (same_ip && !reuse_found_r) begin
        best_idx_r <= best_idx_nxt;
        if (take_best) begin
          best_age_r <= s2_age_r;
        end
        if (reach) begin
          reuse_idx_r <= best_idx_nxt;
        end
      end
    end
  end

  // Finish: choose the slot, update the entry and build the result.
  logic                found;
  logic [2:0]          status;
  logic [IDX_W+3:0]    slot_ext;
  logic [15:0]         mask_all;
  out_item_t           res_nxt;
  out_item_t           out_data_r;
  logic                out_valid_r;

  always_comb begin
    found   = 1'b1;
    sel_idx = hit_idx_r;
    status  = ST_HIT;
    priority if (hit_found_r) begin
      sel_idx = hit_idx_r;
      status  = ST_HIT;
    end else if (reuse_found_r) begin
      sel_idx = reuse_idx_r;
      status  = ST_REUSED;
    end else if (free_found_r) begin
      sel_idx = free_idx_r;
      status  = ST_CREATED;
    end else begin
      found  = 1'b0;
      status = ST_FULL;
    end
  end

  assign ram_we = cmd.finish && !is_tick && found
                  && ((status != ST_HIT) || (cmd_r == CMD_BCAST));
  assign wr_entry.ip        = ip_r;
  assign wr_entry.port      = port_r;
  assign wr_entry.last_seen = sec_r;

  for (genvar k = 0; k < 16; k++) begin : g_mask
    if (k < TABLE_ENTRIES) begin : g_on
      assign mask_all[k] = valid_r[k] && (sel_idx != IDX_W'(k));
    end else begin : g_off
      assign mask_all[k] = 1'b0;
    end
  end

  assign slot_ext = {4'b0000, sel_idx};

  always_comb begin
    res_nxt = '0;
    if (is_tick) begin
      res_nxt.status       = ST_TICK;
      res_nxt.online_count = online_r;
      res_nxt.idle_count   = idle_r;
    end else begin
      res_nxt.status = status;
      if (found) begin
        res_nxt.slot = slot_ext[3:0];
        if (cmd_r == CMD_BCAST) begin
          res_nxt.forward_mask = mask_all;
        end else if (cmd_r == CMD_ADDR_QUERY) begin
          res_nxt.reply_valid = 1'b1;
          res_nxt.reply_ip    = ip_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (s2_v_r && is_tick && ent_valid && (s2_age_r > hard_timeout_r)) begin
      valid_r[s2_idx_r] <= 1'b0;
    end else if (cmd.finish && !is_tick && found) begin
      valid_r[sel_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/client_session_table.sv -----
`timescale 1ns / 1ps
// Top level of the client session table: controller, datapath and port wiring.
//
//   channel  handshake              payload
//   input    start / busy           in_data   (cst_pkg::in_item_t)
//   result   out_valid strobe       out_data  (cst_pkg::out_item_t)
//   config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item scans the entry RAM one entry per cycle; busy falls as the result appears on the
// ports, in time for the next item to be taken in that same cycle.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset empties the table at once through per-entry valid bits, with no clearing pass.
// Configuration beats are always taken.
module client_session_table #(
  parameter int unsigned TABLE_ENTRIES = cst_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  cst_pkg::in_item_t              in_data,
  output logic                           out_valid,
  output cst_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cst_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cst_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  ctl_cmd_t         ctl_cmd;
  logic [IDX_W-1:0] rd_addr;

  assign cfg_ready = 1'b1;

  cst_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .cmd     (ctl_cmd),
    .rd_addr (rd_addr)
  );

  cst_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ctl_cmd),
    .rd_addr   (rd_addr),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.finish |=> out_valid)
    else $error("Finish step did not produce a result beat.");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result beat while the table is still busy.");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted item did not raise busy.");

  a_full_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_FULL)) |->
      ((out_data.slot == 4'd0) && (out_data.forward_mask == 16'd0)
       && !out_data.reply_valid))
    else $error("Table-full result carries a slot, mask or reply.");
`endif

endmodule

// ----- tb/tb_client_session_table.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the client session table: directed plan, then randomised phases.
module tb_client_session_table;
  import cst_pkg::*;

  localparam int unsigned N = TABLE_ENTRIES_DEF;
  localparam int unsigned POOL_IPS = 6;
  localparam int unsigned POOL_PORTS = 4;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 300;
  localparam int unsigned SETTLE = 4;
  localparam int unsigned TAIL = N + 8;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned MAX_PRINTS = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    bit                   is_cfg;
    bit                   typed;
    logic [4:0]           reps;
    in_item_t             item;
    out_item_t            want;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [31:0]          reg_val;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_data = '0;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit          tbl_valid [N];
  logic [31:0] tbl_ip [N];
  logic [15:0] tbl_port [N];
  logic [31:0] tbl_seen [N];
  logic [31:0] secs;
  logic [4:0]  lim_r;
  logic [15:0] soft_r;
  logic [31:0] hard_r;
  logic [15:0] oport_r;
  logic        oen_r;

  out_item_t   pending_results [$];
  plan_row_t   plan [$];
  logic [31:0] addr_pool [POOL_IPS];
  logic [15:0] port_pool [POOL_PORTS];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  client_session_table #(.TABLE_ENTRIES(N)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_client_session_table NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected");
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(out_data.status), 32'(want.status));
        check_field("slot", 32'(out_data.slot), 32'(want.slot));
        check_field("forward_mask", 32'(out_data.forward_mask), 32'(want.forward_mask));
        check_field("reply_valid", 32'(out_data.reply_valid), 32'(want.reply_valid));
        check_field("reply_ip", out_data.reply_ip, want.reply_ip);
        check_field("online_count", 32'(out_data.online_count), 32'(want.online_count));
        check_field("idle_count", 32'(out_data.idle_count), 32'(want.idle_count));
      end
    end
  end

  task automatic reset_table_state();
    for (int i = 0; i < N; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_ip[i] = '0;
      tbl_port[i] = '0;
      tbl_seen[i] = '0;
    end
    secs = '0;
    lim_r = IP_LIMIT_RST;
    soft_r = SOFT_TIMEOUT_RST;
    hard_r = HARD_TIMEOUT_RST;
    oport_r = PORT_OVERRIDE_RST;
    oen_r = OVERRIDE_EN_RST;
  endtask

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    unique case (idx)
      REG_IP_LIMIT:      lim_r = d[4:0];
      REG_SOFT_TIMEOUT:  soft_r = d[15:0];
      REG_HARD_TIMEOUT:  hard_r = d;
      REG_PORT_OVERRIDE: oport_r = d[15:0];
      REG_OVERRIDE_EN:   oen_r = d[0];
      default: ;
    endcase
  endfunction

  function automatic void claim_entry(int i, logic [31:0] ip, logic [15:0] port);
    tbl_valid[i] = 1'b1;
    tbl_ip[i] = ip;
    tbl_port[i] = port;
    tbl_seen[i] = secs;
  endfunction

  function automatic out_item_t session_lookup(in_item_t it);
    out_item_t   r;
    logic [31:0] age;
    logic [31:0] best_age;
    logic [15:0] eport;
    logic [4:0]  limit;
    int          cnt;
    int          best;
    int          hit;
    bit          found;
    bit          have;
    r = '0;
    if (it.cmd == CMD_TICK) begin
      secs = secs + 32'd1;
      for (int i = 0; i < N; i++) begin
        if (tbl_valid[i]) begin
          age = secs - tbl_seen[i];
          if (age > hard_r) begin
            tbl_valid[i] = 1'b0;
            tbl_ip[i] = '0;
            tbl_port[i] = '0;
            tbl_seen[i] = '0;
          end else if (age > soft_r) begin
            if (r.idle_count != COUNT_SAT) r.idle_count = r.idle_count + 5'd1;
          end else begin
            if (r.online_count != COUNT_SAT) r.online_count = r.online_count + 5'd1;
          end
        end
      end
      r.status = ST_TICK;
    end else begin
      eport = oen_r ? oport_r : it.src_port;
      limit = (lim_r == 5'd0) ? 5'd1 : lim_r;
      found = 1'b0;
      hit = 0;
      for (int i = 0; i < N && !found; i++) begin
        if (tbl_valid[i] && tbl_ip[i] == it.src_ip && tbl_port[i] == eport) begin
          hit = i;
          found = 1'b1;
          r.status = ST_HIT;
        end
      end
      if (!found) begin
        cnt = 0;
        best = 0;
        best_age = '0;
        have = 1'b0;
        for (int i = 0; i < N && !found; i++) begin
          if (tbl_valid[i] && tbl_ip[i] == it.src_ip) begin
            age = secs - tbl_seen[i];
            if (!have || age > best_age) begin
              best_age = age;
              best = i;
              have = 1'b1;
            end
            cnt++;
            if (cnt >= limit) begin
              claim_entry(best, it.src_ip, eport);
              hit = best;
              found = 1'b1;
              r.status = ST_REUSED;
            end
          end
        end
        for (int i = 0; i < N && !found; i++) begin
          if (!tbl_valid[i]) begin
            claim_entry(i, it.src_ip, eport);
            hit = i;
            found = 1'b1;
            r.status = ST_CREATED;
          end
        end
        if (!found) r.status = ST_FULL;
      end
      if (found) begin
        r.slot = hit[3:0];
        if (it.cmd == CMD_BCAST) begin
          tbl_seen[hit] = secs;
          for (int i = 0; i < N && i < 16; i++) begin
            if (tbl_valid[i] && i != hit) r.forward_mask[i] = 1'b1;
          end
        end else if (it.cmd == CMD_ADDR_QUERY) begin
          r.reply_valid = 1'b1;
          r.reply_ip = tbl_ip[hit];
        end
      end
    end
    return r;
  endfunction

  function automatic out_item_t result_of(logic [2:0] st, logic [3:0] sl, logic [15:0] mask,
                                          logic rv, logic [31:0] rip, logic [4:0] on,
                                          logic [4:0] idl);
    out_item_t r;
    r.status = st;
    r.slot = sl;
    r.forward_mask = mask;
    r.reply_valid = rv;
    r.reply_ip = rip;
    r.online_count = on;
    r.idle_count = idl;
    return r;
  endfunction

  function automatic void add_item(logic [1:0] c, logic [31:0] ip, logic [15:0] port, int n);
    plan_row_t row;
    row = '0;
    row.reps = n[4:0];
    row.item.cmd = c;
    row.item.src_ip = ip;
    row.item.src_port = port;
    plan.push_back(row);
  endfunction

  function automatic void add_checked(logic [1:0] c, logic [31:0] ip, logic [15:0] port,
                                      out_item_t w);
    plan_row_t row;
    row = '0;
    row.typed = 1'b1;
    row.reps = 5'd1;
    row.item.cmd = c;
    row.item.src_ip = ip;
    row.item.src_port = port;
    row.want = w;
    plan.push_back(row);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    plan.push_back(row);
  endfunction

  task automatic pause(int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_reg_write(idx, d);
  endtask

  task automatic send_item(in_item_t it, bit use_typed, out_item_t typed_want);
    out_item_t predicted;
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = session_lookup(it);
    pending_results.push_back(use_typed ? typed_want : predicted);
  endtask

  task automatic configure_phase(int unsigned ph);
    logic [4:0]  lim;
    logic [15:0] soft_to;
    logic [31:0] hard;
    logic [15:0] oport;
    logic        oen;
    logic [31:0] d;
    case (ph)
      0: begin
        lim = 5'd1; soft_to = 16'd0; hard = 32'd3; oport = 16'h0000; oen = 1'b0;
      end
      1: begin
        lim = 5'd16; soft_to = 16'hFFFF; hard = 32'hFFFF_FFFF; oport = 16'hFFFF; oen = 1'b1;
      end
      2: begin
        lim = 5'd31; soft_to = 16'd2; hard = 32'd8; oport = 16'($urandom()); oen = 1'b0;
      end
      default: begin
        lim = 5'($urandom_range(0, 31));
        soft_to = 16'($urandom_range(0, 6));
        hard = $urandom_range(1, 30);
        oport = 16'($urandom());
        oen = 1'($urandom_range(0, 1));
      end
    endcase
    d = $urandom();
    d[4:0] = lim;
    write_reg(REG_IP_LIMIT, d);
    d = $urandom();
    d[15:0] = soft_to;
    write_reg(REG_SOFT_TIMEOUT, d);
    write_reg(REG_HARD_TIMEOUT, hard);
    d = $urandom();
    d[15:0] = oport;
    write_reg(REG_PORT_OVERRIDE, d);
    d = $urandom();
    d[0] = oen;
    write_reg(REG_OVERRIDE_EN, d);
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) it.cmd = CMD_TICK;
    else if (r < 45) it.cmd = CMD_BCAST;
    else if (r < 70) it.cmd = CMD_ADDR_QUERY;
    else it.cmd = CMD_OTHER;
    if ($urandom_range(0, 9) == 0) it.src_ip = $urandom();
    else it.src_ip = addr_pool[$urandom_range(0, POOL_IPS - 1)];
    if ($urandom_range(0, 9) == 0) it.src_port = 16'($urandom());
    else it.src_port = port_pool[$urandom_range(0, POOL_PORTS - 1)];
    return it;
  endfunction

  function automatic int unsigned sender_gap(bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    in_item_t it;
    bit       burst;
    reset_table_state();

    add_checked(CMD_TICK, 32'h0, 16'h0, result_of(ST_TICK, 0, 16'h0, 0, 32'h0, 0, 0));
    add_checked(CMD_ADDR_QUERY, 32'hFFFF_FFFF, 16'h0000,
                result_of(ST_CREATED, 0, 16'h0, 1, 32'hFFFF_FFFF, 0, 0));
    add_checked(CMD_BCAST, 32'h0000_0000, 16'hFFFF,
                result_of(ST_CREATED, 1, 16'h0001, 0, 32'h0, 0, 0));
    add_checked(CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF, result_of(ST_TICK, 0, 16'h0, 0, 32'h0, 2, 0));
    add_reg(REG_OVERRIDE_EN, 32'h0);
    add_reg(REG_IP_LIMIT, 32'd2);
    add_checked(CMD_OTHER, 32'h0A00_0001, 16'd1, result_of(ST_CREATED, 2, 16'h0, 0, 32'h0, 0, 0));
    add_checked(CMD_OTHER, 32'h0A00_0001, 16'd2, result_of(ST_CREATED, 3, 16'h0, 0, 32'h0, 0, 0));
    add_checked(CMD_OTHER, 32'h0A00_0001, 16'd3, result_of(ST_REUSED, 2, 16'h0, 0, 32'h0, 0, 0));
    add_reg(REG_IP_LIMIT, 32'd0);
    add_checked(CMD_ADDR_QUERY, 32'h0A00_0001, 16'd9,
                result_of(ST_REUSED, 2, 16'h0, 1, 32'h0A00_0001, 0, 0));
    add_reg(REG_HARD_TIMEOUT, 32'h0);
    add_reg(REG_SOFT_TIMEOUT, 32'h0);
    add_checked(CMD_TICK, 32'h0, 16'h0, result_of(ST_TICK, 0, 16'h0, 0, 32'h0, 0, 0));
    add_reg(REG_HARD_TIMEOUT, 32'hFFFF_FFFF);
    add_reg(REG_SOFT_TIMEOUT, 32'h0000_FFFF);
    add_reg(REG_PORT_OVERRIDE, 32'h0000_FFFF);
    add_reg(REG_OVERRIDE_EN, 32'h1);
    add_reg(REG_IP_LIMIT, 32'd31);
    add_item(CMD_OTHER, 32'h55AA_0000, 16'h0, N);
    add_checked(CMD_BCAST, 32'h0000_0001, 16'h0, result_of(ST_FULL, 0, 16'h0, 0, 32'h0, 0, 0));
    add_checked(CMD_BCAST, 32'h55AA_0003, 16'h1234,
                result_of(ST_HIT, 3, 16'hFFF7, 0, 32'h0, 0, 0));
    add_checked(CMD_TICK, 32'h0, 16'h0, result_of(ST_TICK, 0, 16'h0, 0, 32'h0, 16, 0));
    add_reg(REG_SOFT_TIMEOUT, 32'h0);
    add_checked(CMD_TICK, 32'h0, 16'h0, result_of(ST_TICK, 0, 16'h0, 0, 32'h0, 0, 16));
    add_reg(REG_PORT_OVERRIDE, 32'h0);
    add_reg(REG_SPARE_HI, 32'hFFFF_FFFF);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        pause(1);
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
        cfg_valid <= 1'b0;
      end else begin
        for (int k = 0; k < plan[i].reps; k++) begin
          it = plan[i].item;
          it.src_ip = it.src_ip + k;
          send_item(it, plan[i].typed, plan[i].want);
        end
      end
    end

    burst = 1'b0;
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      pause(1);
      wait_idle();
      foreach (addr_pool[j]) addr_pool[j] = $urandom();
      foreach (port_pool[j]) port_pool[j] = 16'($urandom());
      configure_phase(ph);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) burst = ($urandom_range(0, 2) == 0);
        if ((ph == 0 && k == PHASE_ITEMS / 2) || $urandom_range(0, 149) == 0) begin
          pause(1);
          wait_idle();
        end else begin
          pause(sender_gap(burst));
        end
        send_item(random_item(), 1'b0, '0);
      end
    end

    pause(1);
    wait_idle();
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0) $display("tb_client_session_table OK");
    else $display("tb_client_session_table NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/cst_pkg.sv
rtl/core/cst_ram.sv
rtl/core/cst_ctrl.sv
rtl/core/cst_datapath.sv
rtl/core/client_session_table.sv
tb/tb_client_session_table.sv
